// File: sv/tsns_pkg.sv
// Shared types and constants of the tune stream note sequencer.
package tsns_pkg;

	// Name bytes skipped between the note count and the tempo (0 to 63).
	localparam int unsigned NAME_BYTES = 16;
	// Byte counter width, wide enough to count the longest name.
	localparam int unsigned POS_W = 6;
	// Record lengths in bytes for the two record formats.
	localparam int unsigned REC_LEN_NOTE = 3;
	localparam int unsigned REC_LEN_FREQ = 6;

	// Wait scaling: wait = value * tempo * 97 / 10000.
	localparam int unsigned SCALE_MUL = 97;
	localparam int unsigned DIV_CONST = 10000;
	localparam int unsigned PROD_W = 31;
	localparam int unsigned SCALED_W = 37;
	localparam int unsigned QUO_W = 16;
	// The division by 10000 drops four low bits, then multiplies by the rounded-up
	// reciprocal of 625 scaled by 2**36; this is exact for every unsaturated product.
	localparam int unsigned DIV_PRE_SHIFT = 4;
	localparam int unsigned DVD_W = 26;
	localparam int unsigned RECIP_W = 27;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam longint unsigned RECIP_MUL = 64'd109951163;
	// Smallest scaled product whose quotient no longer fits 16 bits.
	localparam longint unsigned SAT_LIMIT = 64'd655360000;

	// Configuration port.
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_IDX_FORMAT = 1'b0;
	localparam logic REG_IDX_MUTE = 1'b1;

	// One byte of the tune file.
	typedef struct packed {
		logic [7:0] stream_byte;
		logic start_of_file;
	} src_item_t;

	// One tone event.
	typedef struct packed {
		logic tone_on;
		logic signed [15:0] pitch;
		logic signed [15:0] tone_length;
		logic [15:0] wait_time;
		logic last_record;
	} tone_item_t;

	// Record completed by the current byte, with the value to be scaled.
	typedef struct packed {
		logic fire;
		logic tone_on;
		logic signed [15:0] pitch;
		logic signed [15:0] tone_length;
		logic last_record;
		logic signed [15:0] scale_value;
	} rec_evt_t;

	// Requests to the scaling unit.
	typedef struct packed {
		logic start;
		logic ack;
	} scl_ctrl_t;

	// Status of the scaling unit.
	typedef struct packed {
		logic busy;
		logic done;
	} scl_stat_t;

endpackage

// File: sv/tsns_parse.sv
// Byte parser for the tune header and note records.
module tsns_parse (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input tsns_pkg::src_item_t item,
	input logic record_format,
	output tsns_pkg::rec_evt_t evt,
	output logic [15:0] tempo
);
	import tsns_pkg::*;

	typedef enum logic [4:0] {
		PH_COUNT = 5'b00001,
		PH_NAME  = 5'b00010,
		PH_TEMPO = 5'b00100,
		PH_REC   = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	phase_t phase_q, phase_d, eff_phase;
	logic [POS_W-1:0] pos_q, pos_d, eff_pos, next_pos, rec_len;
	logic [15:0] notes_q, notes_d, eff_notes, count_shift, notes_dec;
	logic [15:0] tempo_q, tempo_d;
	logic [47:0] fa_q, fa_d, fa_shift;
	logic [15:0] pitch_raw;
	logic rec_tone_on;

	// A start-of-file byte restarts parsing before it is taken as the count's high byte.
	assign eff_phase = item.start_of_file ? PH_COUNT : phase_q;
	assign eff_pos = item.start_of_file ? '0 : pos_q;
	assign eff_notes = item.start_of_file ? '0 : notes_q;

	// Shifted fields and record decoding.
	assign count_shift = {eff_notes[7:0], item.stream_byte};
	assign notes_dec = eff_notes - 16'd1;
	assign next_pos = eff_pos + POS_W'(1);
	assign fa_shift = {fa_q[39:0], item.stream_byte};
	assign rec_len = record_format ? POS_W'(REC_LEN_FREQ) : POS_W'(REC_LEN_NOTE);
	assign pitch_raw = record_format ? fa_shift[47:32] : {8'd0, fa_shift[23:16]};
	assign rec_tone_on = !pitch_raw[15] && (pitch_raw != 16'd0);

	// Next parse state for the byte on the input.
	always_comb begin
		phase_d = eff_phase;
		pos_d = eff_pos;
		notes_d = eff_notes;
		tempo_d = tempo_q;
		fa_d = fa_q;
		evt.fire = 1'b0;
		evt.tone_on = rec_tone_on;
		evt.pitch = rec_tone_on ? pitch_raw : 16'sd0;
		evt.tone_length = record_format ? fa_shift[31:16] : fa_shift[15:0];
		evt.last_record = (notes_dec == 16'd0);
		evt.scale_value = fa_shift[15:0];
		case (eff_phase)
			PH_COUNT: begin
				notes_d = count_shift;
				if (eff_pos == '0) begin
					pos_d = POS_W'(1);
				end else begin
					// A negative count plays nothing.
					if (count_shift[15]) begin
						notes_d = '0;
					end
					pos_d = '0;
					phase_d = (NAME_BYTES > 0) ? PH_NAME : PH_TEMPO;
				end
			end
			PH_NAME: begin
				pos_d = next_pos;
				if (next_pos >= POS_W'(NAME_BYTES)) begin
					pos_d = '0;
					phase_d = PH_TEMPO;
				end
			end
			PH_TEMPO: begin
				tempo_d = {tempo_q[7:0], item.stream_byte};
				if (eff_pos == '0) begin
					pos_d = POS_W'(1);
				end else begin
					pos_d = '0;
					fa_d = '0;
					phase_d = (eff_notes == 16'd0) ? PH_DONE : PH_REC;
				end
			end
			PH_REC: begin
				fa_d = fa_shift;
				pos_d = next_pos;
				// The record ends once the byte count reaches the current length.
				if (next_pos >= rec_len) begin
					evt.fire = 1'b1;
					notes_d = notes_dec;
					pos_d = '0;
					fa_d = '0;
					if (notes_dec == 16'd0) begin
						phase_d = PH_DONE;
					end
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	// Parse state, updated on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			pos_q <= '0;
			notes_q <= '0;
			tempo_q <= '0;
			fa_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			notes_q <= notes_d;
			tempo_q <= tempo_d;
			fa_q <= fa_d;
		end
	end

	assign tempo = tempo_q;

endmodule

// File: sv/tsns_scale.sv
// Iterative wait scaling unit: multiply by tempo and 97, then divide by 10000.
module tsns_scale (
	input logic clk,
	input logic arst_n,
	input tsns_pkg::scl_ctrl_t ctrl,
	input logic signed [15:0] value,
	input logic signed [15:0] tempo,
	output tsns_pkg::scl_stat_t stat,
	output logic [15:0] wait_time
);
	import tsns_pkg::*;

	typedef enum logic [5:0] {
		SC_IDLE = 6'b000001,
		SC_MUL1 = 6'b000010,
		SC_MUL2 = 6'b000100,
		SC_PREP = 6'b001000,
		SC_DIV  = 6'b010000,
		SC_DONE = 6'b100000
	} scl_state_t;

	scl_state_t state_q;
	logic [15:0] mag_v_q, mag_t_q;
	logic neg_q, sat_q;
	logic [PROD_W-1:0] prod_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [DVD_W-1:0] dvd_q;
	logic [QUO_W-1:0] quo_q;
	logic [DVD_W+RECIP_W-1:0] recip_prod;

	// Reciprocal multiplication that replaces the division by the constant.
	assign recip_prod = (DVD_W+RECIP_W)'(dvd_q) * (DVD_W+RECIP_W)'(RECIP_MUL);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			case (state_q)
				SC_IDLE: begin
					if (ctrl.start) begin
						state_q <= SC_MUL1;
					end
				end
				SC_MUL1: state_q <= SC_MUL2;
				SC_MUL2: state_q <= SC_PREP;
				SC_PREP: state_q <= SC_DIV;
				SC_DIV: state_q <= SC_DONE;
				SC_DONE: begin
					if (ctrl.ack) begin
						state_q <= SC_IDLE;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	// Operand magnitudes, products, and the quotient.
	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				mag_v_q <= value[15] ? 16'(~value + 16'sd1) : 16'(value);
				mag_t_q <= tempo[15] ? 16'(~tempo + 16'sd1) : 16'(tempo);
				neg_q <= value[15] ^ tempo[15];
			end
			SC_MUL1: prod_q <= PROD_W'(mag_v_q * mag_t_q);
			SC_MUL2: scaled_q <= SCALED_W'(prod_q) * SCALED_W'(SCALE_MUL);
			SC_PREP: begin
				// Below the limit the product fits 30 bits, so dropping four bits leaves 26.
				sat_q <= (64'(scaled_q) >= SAT_LIMIT);
				dvd_q <= scaled_q[DIV_PRE_SHIFT+DVD_W-1:DIV_PRE_SHIFT];
			end
			SC_DIV: quo_q <= recip_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
			default: begin
			end
		endcase
	end

	// A negative product gives no wait; an oversized one saturates.
	assign wait_time = neg_q ? 16'd0 : (sat_q ? 16'hFFFF : quo_q);
	assign stat.busy = (state_q != SC_IDLE);
	assign stat.done = (state_q == SC_DONE);

endmodule

// File: sv/tune_stream_note_sequencer.sv
// Top level: configuration registers, handshakes and the tone event output register.
// A byte that does not end a record is taken without a stall; bytes may follow back to back.
// A byte that ends an unmuted record holds off input while the scaling unit
// multiplies (MUL1, MUL2), prepares (PREP), divides by reciprocal (DIV) and hands over (DONE).
// Its tone event is registered when the result is handed over; a held output event lengthens the stall.
// Reset (arst_n low, asynchronous) clears parse state, configuration, control states and the valid flag; no sweep.
module tune_stream_note_sequencer (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tsns_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic src_valid,
	output logic src_ready,
	input tsns_pkg::src_item_t src_data,
	output logic tone_valid,
	input logic tone_ready,
	output tsns_pkg::tone_item_t tone_data
);
	import tsns_pkg::*;

	typedef enum logic [1:0] {
		T_IDLE = 2'b01,
		T_CALC = 2'b10
	} ctl_state_t;

	ctl_state_t ctl_q;
	logic fmt_q, mute_q;
	logic accept, start, load;
	rec_evt_t evt;
	logic [15:0] tempo;
	scl_ctrl_t scl_ctrl;
	scl_stat_t scl_stat;
	logic [15:0] scl_wait;
	tone_item_t pend_q, tone_q;
	logic tone_valid_q;

	// Configuration registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
			mute_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_IDX_FORMAT: fmt_q <= pwdata[0];
				REG_IDX_MUTE: mute_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[2])
			REG_IDX_FORMAT: prdata = {31'd0, fmt_q};
			REG_IDX_MUTE: prdata = {31'd0, mute_q};
			default: prdata = '0;
		endcase
	end

	// Input transaction and the start of a scaling run.
	assign src_ready = (ctl_q == T_IDLE);
	assign accept = src_valid && src_ready;
	assign start = accept && evt.fire && !mute_q;
	assign load = (ctl_q == T_CALC) && scl_stat.done && (!tone_valid_q || tone_ready);
	assign scl_ctrl.start = start;
	assign scl_ctrl.ack = load;

	tsns_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(src_data),
		.record_format(fmt_q),
		.evt(evt),
		.tempo(tempo)
	);

	tsns_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(scl_ctrl),
		.value(evt.scale_value),
		.tempo(tempo),
		.stat(scl_stat),
		.wait_time(scl_wait)
	);

	// Control state: wait for the scaling unit after a record ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= T_IDLE;
		end else begin
			case (ctl_q)
				T_IDLE: begin
					if (start) begin
						ctl_q <= T_CALC;
					end
				end
				T_CALC: begin
					if (load) begin
						ctl_q <= T_IDLE;
					end
				end
				default: ctl_q <= T_IDLE;
			endcase
		end
	end

	// Record fields held while the wait is computed, and the output register.
	always_ff @(posedge clk) begin
		if (start) begin
			pend_q.tone_on <= evt.tone_on;
			pend_q.pitch <= evt.pitch;
			pend_q.tone_length <= evt.tone_length;
			pend_q.wait_time <= '0;
			pend_q.last_record <= evt.last_record;
		end
		if (load) begin
			tone_q <= {pend_q.tone_on, pend_q.pitch, pend_q.tone_length, scl_wait,
				pend_q.last_record};
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_valid_q <= 1'b0;
		end else if (load) begin
			tone_valid_q <= 1'b1;
		end else if (tone_ready) begin
			tone_valid_q <= 1'b0;
		end
	end

	assign tone_valid = tone_valid_q;
	assign tone_data = tone_q;

`ifndef NO_ASSERTIONS
	// The scaling unit is only started when it is free.
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		scl_ctrl.start |-> !scl_stat.busy)
		else $error("scaling unit started while busy");

	// Input is held off in the cycle after a scaling run starts.
	a_hold_off: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !src_ready)
		else $error("input accepted during a scaling run");

	// A finished scaling run is only seen while the control waits for it.
	a_done_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		scl_stat.done |-> (ctl_q == T_CALC))
		else $error("scaling result with no waiting record");

	// A new tone event only follows a finished scaling run.
	a_rise_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tone_valid) |-> $past(scl_stat.done))
		else $error("tone event without a scaled wait");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the tune stream note sequencer: byte stream in, tone events out.
`timescale 1ns / 100ps

module tb_top;
	import tsns_pkg::*;

	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 460;
	localparam int CALM_AFTER = 400;
	localparam longint WAIT_MUL = longint'(SCALE_MUL);
	localparam longint WAIT_DIV = longint'(DIV_CONST);

	typedef enum logic [2:0] {P_COUNT, P_NAME, P_TEMPO, P_NOTES, P_IDLE} parse_e;
	typedef enum logic [1:0] {ROW_BYTE, ROW_FORMAT, ROW_MUTE} row_kind_e;

	// One line of the directed table; a typed tone is the event the byte must produce.
	typedef struct {
		row_kind_e kind;
		logic [7:0] val;
		logic sof;
		int reps;
		bit typed;
		tone_item_t tone;
	} row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic src_valid = 1'b0;
	logic src_ready;
	src_item_t src_data = '0;
	logic tone_valid;
	logic tone_ready = 1'b0;
	tone_item_t tone_data;

	// Parser state mirrored by the testbench, with its own copy of the registers.
	parse_e phase = P_COUNT;
	int pos = 0;
	logic [15:0] notes_left = '0;
	logic [15:0] tempo_pct = '0;
	logic [47:0] rec_shift = '0;
	logic cfg_format = 1'b0;
	logic cfg_mute = 1'b0;

	tone_item_t pending_tones[$];
	row_t plan[$];
	int errors = 0;
	int random_sent = 0;
	int quiet = 0;
	bit tx_busy = 1'b0;
	logic calm = 1'b0;
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;
	int rx_tick = 0;
	bit rx_busy = 1'b1;
	tone_item_t want;

	tune_stream_note_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data(src_data),
		.tone_valid(tone_valid),
		.tone_ready(tone_ready),
		.tone_data(tone_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Wait value times tempo times 0.0097, truncated toward zero and clamped to 16 bits.
	function automatic logic [15:0] tempo_scaled_wait(input logic [15:0] v);
		longint prod;
		longint quo;
		prod = longint'($signed(v)) * longint'($signed(tempo_pct)) * WAIT_MUL;
		quo = prod / WAIT_DIV;
		if (quo < 0)
			return '0;
		if (quo > 65535)
			return 16'hFFFF;
		return quo[15:0];
	endfunction

	// Advances the mirrored parser by one byte; returns 1 when a tone event is due.
	function automatic bit parse_tune_byte(input logic [7:0] b, input logic sof,
			output tone_item_t ev);
		logic [15:0] pval;
		logic [15:0] dval;
		logic [15:0] wval;
		int rec_len;
		bit fired;
		ev = '0;
		fired = 1'b0;
		if (sof) begin
			phase = P_COUNT;
			pos = 0;
			notes_left = '0;
		end
		case (phase)
			P_COUNT: begin
				notes_left = {notes_left[7:0], b};
				if (pos == 0) begin
					pos = 1;
				end else begin
					// A negative count behaves as zero.
					if (notes_left[15])
						notes_left = '0;
					pos = 0;
					phase = (NAME_BYTES > 0) ? P_NAME : P_TEMPO;
				end
			end
			P_NAME: begin
				pos = pos + 1;
				if (pos >= NAME_BYTES) begin
					pos = 0;
					phase = P_TEMPO;
				end
			end
			P_TEMPO: begin
				tempo_pct = {tempo_pct[7:0], b};
				if (pos == 0) begin
					pos = 1;
				end else begin
					pos = 0;
					rec_shift = '0;
					phase = (notes_left == 0) ? P_IDLE : P_NOTES;
				end
			end
			P_NOTES: begin
				// The record length follows the format register at every byte.
				rec_len = cfg_format ? REC_LEN_FREQ : REC_LEN_NOTE;
				rec_shift = {rec_shift[39:0], b};
				pos = pos + 1;
				if (pos >= rec_len) begin
					if (cfg_format) begin
						pval = rec_shift[47:32];
						dval = rec_shift[31:16];
						wval = rec_shift[15:0];
					end else begin
						pval = {8'h00, rec_shift[23:16]};
						dval = rec_shift[15:0];
						wval = rec_shift[15:0];
					end
					notes_left = notes_left - 16'd1;
					if (!cfg_mute) begin
						ev.tone_on = $signed(pval) > 16'sd0;
						ev.pitch = ev.tone_on ? pval : '0;
						ev.tone_length = dval;
						ev.wait_time = tempo_scaled_wait(wval);
						ev.last_record = (notes_left == 0);
						fired = 1'b1;
					end
					pos = 0;
					rec_shift = '0;
					if (notes_left == 0)
						phase = P_IDLE;
				end
			end
			default: phase = P_IDLE;
		endcase
		return fired;
	endfunction

	function automatic row_t b_row(input logic [7:0] v, input logic sof = 1'b0,
			input int reps = 1);
		row_t r;
		r.kind = ROW_BYTE;
		r.val = v;
		r.sof = sof;
		r.reps = reps;
		r.typed = 1'b0;
		r.tone = '0;
		return r;
	endfunction

	function automatic row_t t_row(input logic [7:0] v, input logic on,
			input logic [15:0] p, input logic [15:0] len, input logic [15:0] w,
			input logic last);
		row_t r;
		r = b_row(v);
		r.typed = 1'b1;
		r.tone.tone_on = on;
		r.tone.pitch = p;
		r.tone.tone_length = len;
		r.tone.wait_time = w;
		r.tone.last_record = last;
		return r;
	endfunction

	function automatic row_t r_row(input row_kind_e k, input logic v);
		row_t r;
		r = b_row(8'h00);
		r.kind = k;
		r.val = {7'b0, v};
		return r;
	endfunction

	function automatic int pick_gap();
		if (calm || !tx_busy || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 15);
	endfunction

	function automatic logic [15:0] rnd16();
		if ($urandom_range(0, 1) == 1)
			return 16'($urandom_range(0, 2000));
		return 16'($urandom);
	endfunction

	// Offers one byte, holds it until the transaction completes and records any expected tone.
	task automatic send_byte(input logic [7:0] b, input logic sof, input bit have_typed,
			input tone_item_t typed);
		int gap;
		bit fired;
		tone_item_t pred;
		src_item_t item;
		gap = pick_gap();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.stream_byte = b;
		item.start_of_file = sof;
		src_valid <= 1'b1;
		src_data <= item;
		do @(posedge clk); while (!src_ready);
		fired = parse_tune_byte(b, sof, pred);
		if (have_typed || fired)
			pending_tones.push_back(have_typed ? typed : pred);
	endtask

	// Stops offering bytes and waits until every expected tone has been taken.
	task automatic drain();
		src_valid <= 1'b0;
		do @(posedge clk); while (pending_tones.size() != 0);
	endtask

	// Register write while the block is idle: setup phase, then access phase.
	task automatic write_reg(input logic idx, input logic val);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {31'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_IDX_FORMAT)
			cfg_format = val;
		else
			cfg_mute = val;
	endtask

	// One random tune file: mostly well formed, sometimes cut short or followed by noise.
	// A kept file has at least two records, is sent whole and keeps its format.
	task automatic send_file(input bit pause_mid, input bit keep_count);
		logic [7:0] fb[$];
		logic [15:0] count16;
		logic [15:0] tempo16;
		logic [15:0] v;
		int pick;
		int nrec;
		int cut;
		int flip_at;
		int pause_at;
		int i;
		pick = keep_count ? 2 : $urandom_range(0, 19);
		if (pick == 0)
			count16 = '0;
		else if (pick == 1)
			count16 = {1'b1, 15'($urandom)};
		else
			count16 = 16'($urandom_range(keep_count ? 2 : 1, 10));
		if ($urandom_range(0, 3) == 0)
			tempo16 = 16'($urandom);
		else
			tempo16 = 16'($urandom_range(0, 300));
		fb.push_back(count16[15:8]);
		fb.push_back(count16[7:0]);
		repeat (NAME_BYTES) fb.push_back(8'($urandom));
		fb.push_back(tempo16[15:8]);
		fb.push_back(tempo16[7:0]);
		if (count16 >= 1 && count16 <= 10)
			nrec = int'(count16) + $urandom_range(0, 1);
		else
			nrec = 2;
		repeat (nrec) begin
			if (cfg_format) begin
				repeat (3) begin
					v = rnd16();
					fb.push_back(v[15:8]);
					fb.push_back(v[7:0]);
				end
			end else begin
				fb.push_back(8'($urandom));
				v = rnd16();
				fb.push_back(v[15:8]);
				fb.push_back(v[7:0]);
			end
		end
		cut = (!keep_count && $urandom_range(0, 7) == 0) ?
			$urandom_range(1, fb.size()) : fb.size();
		flip_at = (!keep_count && $urandom_range(0, 5) == 0) ?
			$urandom_range(NAME_BYTES + 4, fb.size() - 1) : -1;
		pause_at = pause_mid ? fb.size() / 2 : -1;
		for (i = 0; i < cut; i++) begin
			if (i == flip_at)
				write_reg(REG_IDX_FORMAT, !cfg_format);
			if (i == pause_at)
				drain();
			if (random_sent == CALM_AFTER)
				calm <= 1'b1;
			send_byte(fb[i], i == 0, 1'b0, '0);
			random_sent++;
		end
		// Stray bytes without a restart.
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
	endtask

	// Tone receiver: checks each transaction and stalls in bursts or one long hold-off.
	always @(posedge clk) begin
		if (tone_valid && tone_ready) begin
			if (pending_tones.size() == 0) begin
				$error("tone event with none expected: %h", tone_data);
				errors++;
			end else begin
				want = pending_tones.pop_front();
				if (tone_data.tone_on !== want.tone_on) begin
					$error("tone_on: expected %0d, got %0d", want.tone_on, tone_data.tone_on);
					errors++;
				end
				if (tone_data.pitch !== want.pitch) begin
					$error("pitch: expected %0d, got %0d", want.pitch, tone_data.pitch);
					errors++;
				end
				if (tone_data.tone_length !== want.tone_length) begin
					$error("tone_length: expected %0d, got %0d", want.tone_length,
						tone_data.tone_length);
					errors++;
				end
				if (tone_data.wait_time !== want.wait_time) begin
					$error("wait_time: expected %0d, got %0d", want.wait_time,
						tone_data.wait_time);
					errors++;
				end
				if (tone_data.last_record !== want.last_record) begin
					$error("last_record: expected %0d, got %0d", want.last_record,
						tone_data.last_record);
					errors++;
				end
			end
		end
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_busy = $urandom_range(0, 1);
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			tone_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			tone_ready <= 1'b0;
		end else if (!calm && rx_busy && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			tone_ready <= 1'b0;
		end else begin
			tone_ready <= 1'b1;
		end
	end

	// Watchdog on cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if ((src_valid && src_ready) || (tone_valid && tone_ready) || psel)
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Stimulus: reset, the directed table, then random tune files.
	initial begin
		int files;
		int i;
		files = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two records at tempo 100: widest and narrowest duration, then a stray byte.
		plan.push_back(b_row(8'h00, 1'b1));
		plan.push_back(b_row(8'h02));
		plan.push_back(b_row(8'hFF, 1'b0, NAME_BYTES));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h64));
		plan.push_back(b_row(8'hFF));
		plan.push_back(b_row(8'h7F));
		plan.push_back(t_row(8'hFF, 1'b1, 16'd255, 16'h7FFF, 16'd31783, 1'b0));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h80));
		plan.push_back(t_row(8'h00, 1'b0, 16'd0, 16'h8000, 16'd0, 1'b1));
		plan.push_back(b_row(8'hA5));
		// Largest count and tempo saturate the wait; a restart then cuts a record short.
		plan.push_back(b_row(8'h7F, 1'b1));
		plan.push_back(b_row(8'hFF));
		plan.push_back(b_row(8'h00, 1'b0, NAME_BYTES));
		plan.push_back(b_row(8'h7F));
		plan.push_back(b_row(8'hFF));
		plan.push_back(b_row(8'h01));
		plan.push_back(b_row(8'h7F));
		plan.push_back(t_row(8'hFF, 1'b1, 16'd1, 16'h7FFF, 16'hFFFF, 1'b0));
		plan.push_back(b_row(8'h10));
		// Most negative tempo clamps the wait to zero.
		plan.push_back(b_row(8'h00, 1'b1));
		plan.push_back(b_row(8'h01));
		plan.push_back(b_row(8'hC3, 1'b0, NAME_BYTES));
		plan.push_back(b_row(8'h80));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h05));
		plan.push_back(b_row(8'h00));
		plan.push_back(t_row(8'h10, 1'b1, 16'd5, 16'd16, 16'd0, 1'b1));
		// Negative and zero counts: the header is parsed and the records are ignored.
		plan.push_back(b_row(8'h80, 1'b1));
		plan.push_back(b_row(8'h01));
		plan.push_back(b_row(8'h00, 1'b0, NAME_BYTES));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h64));
		plan.push_back(b_row(8'h01, 1'b0, 6));
		plan.push_back(b_row(8'h00, 1'b1));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h00, 1'b0, NAME_BYTES));
		plan.push_back(b_row(8'h01));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h33, 1'b0, 3));
		// Frequency records: one plain, one with a negative frequency and wait.
		plan.push_back(r_row(ROW_FORMAT, 1'b1));
		plan.push_back(b_row(8'h00, 1'b1));
		plan.push_back(b_row(8'h03));
		plan.push_back(b_row(8'h5A, 1'b0, NAME_BYTES));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h64));
		plan.push_back(b_row(8'h01));
		plan.push_back(b_row(8'hB8));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'hFA));
		plan.push_back(b_row(8'h00));
		plan.push_back(t_row(8'h64, 1'b1, 16'd440, 16'd250, 16'd97, 1'b0));
		plan.push_back(b_row(8'hFF));
		plan.push_back(b_row(8'h38));
		plan.push_back(b_row(8'h01));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'hFF));
		plan.push_back(t_row(8'hFF, 1'b0, 16'd0, 16'd256, 16'd0, 1'b0));
		// The third record is muted: counted but silent.
		plan.push_back(r_row(ROW_MUTE, 1'b1));
		plan.push_back(b_row(8'h12, 1'b0, 6));
		plan.push_back(r_row(ROW_MUTE, 1'b0));
		// Format changed in the middle of a record, in both directions.
		plan.push_back(b_row(8'h00, 1'b1));
		plan.push_back(b_row(8'h02));
		plan.push_back(b_row(8'h00, 1'b0, NAME_BYTES));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'hC8));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h2A));
		plan.push_back(b_row(8'h01));
		plan.push_back(b_row(8'h00));
		plan.push_back(r_row(ROW_FORMAT, 1'b0));
		plan.push_back(b_row(8'h10));
		plan.push_back(b_row(8'h07));
		plan.push_back(b_row(8'h00));
		plan.push_back(r_row(ROW_FORMAT, 1'b1));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h20));
		plan.push_back(b_row(8'h00));
		plan.push_back(b_row(8'h40));

		tx_busy = $urandom_range(0, 1);
		for (i = 0; i < plan.size(); i++) begin
			case (plan[i].kind)
				ROW_FORMAT: write_reg(REG_IDX_FORMAT, plan[i].val[0]);
				ROW_MUTE: write_reg(REG_IDX_MUTE, plan[i].val[0]);
				default: begin
					repeat (plan[i].reps)
						send_byte(plan[i].val, plan[i].sof, plan[i].typed, plan[i].tone);
				end
			endcase
		end

		// Random files; the second one, unmuted and complete, runs into a long receiver hold-off.
		while (random_sent < RANDOM_ITEMS) begin
			if (files == 0 || $urandom_range(0, 3) == 0) begin
				write_reg(REG_IDX_FORMAT, 1'($urandom_range(0, 1)));
				write_reg(REG_IDX_MUTE, files > 1 && $urandom_range(0, 4) == 0);
			end
			if (files == 1)
				hold_req <= hold_req + 1;
			tx_busy = $urandom_range(0, 1);
			send_file(files == 3, files == 1);
			files++;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_tones.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: files.f
sv/tsns_pkg.sv
sv/tsns_parse.sv
sv/tsns_scale.sv
sv/tune_stream_note_sequencer.sv
tb/tb_top.sv
